// File: design/mcosp_pkg.sv
// ----------------------------------------------------------------------------
// mcosp_pkg
// Types and constants shared by the multi-channel one-shot pulser modules.
// ----------------------------------------------------------------------------
package mcosp_pkg;

  localparam logic [15:0] MAX_PULSE_RESET        = 16'hFFFF;
  localparam logic [15:0] TIME_SAT               = 16'hFFFF;
  localparam int unsigned CHAN_SLOT_MAX          = 8;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] MODE_DIGITAL = 2'd0;
  localparam logic [1:0] MODE_ANALOG  = 2'd1;
  localparam logic [1:0] MODE_DRY     = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    EMIT_FIRST,
    EMIT_SECOND,
    EMIT_REPORT
  } emit_sel_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  chan;
    logic [5:0]  pin;
    logic [7:0]  first_value;
    logic [15:0] duration_ms;
    logic [7:0]  second_value;
    logic [1:0]  write_mode;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  out_pin;
    logic [7:0]  out_value;
    logic [1:0]  out_mode;
    logic [15:0] elapsed_ms;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic      load_chan;
    logic      start_run;
    logic      tick;
    logic      set_active;
    logic      finish_chan;
    logic      end_run;
    logic      emit;
    emit_sel_e emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic running;
    logic any_loaded;
    logic cur_loaded;
    logic cur_active;
    logic cur_due;
    logic out_free;
  } dp_status_t;

endpackage

// File: design/mcosp_dpath.sv
// ----------------------------------------------------------------------------
// mcosp_dpath
// Channel tables, run timer, limit register and output register.
// ----------------------------------------------------------------------------
module mcosp_dpath #(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned IDX_W = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mcosp_pkg::in_item_t  in_data_i,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  mcosp_pkg::dp_cmd_t   cmd_i,
  input  logic [IDX_W-1:0]     idx_i,
  output mcosp_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mcosp_pkg::out_item_t out_data_o
);
  import mcosp_pkg::*;

  logic [5:0]  pin_q    [SLOTS];
  logic [7:0]  first_q  [SLOTS];
  logic [15:0] dur_q    [SLOTS];
  logic [7:0]  second_q [SLOTS];
  logic [15:0] elapsed_q[SLOTS];
  logic [SLOTS-1:0] loaded_q, active_q;
  logic [15:0] run_time_q, max_q;
  logic [1:0]  run_mode_q;
  logic        running_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic            load_ok;
  logic [IDX_W-1:0] load_idx;
  logic [1:0]      mode_d;
  logic            cur_last;
  out_item_t       out_d;

  assign load_ok  = {3'b000, in_data_i.chan} < 6'(SLOTS);
  assign load_idx = IDX_W'(in_data_i.chan);
  assign mode_d   = (in_data_i.write_mode == MODE_UNUSED) ? MODE_DRY : in_data_i.write_mode;
  assign cur_last = (loaded_q >> idx_i) == SLOTS'(1);

  assign status_o.running    = running_q;
  assign status_o.any_loaded = |loaded_q;
  assign status_o.cur_loaded = loaded_q[idx_i];
  assign status_o.cur_active = active_q[idx_i];
  assign status_o.cur_due    = (run_time_q >= dur_q[idx_i]) || (run_time_q >= max_q);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d          = '0;
    out_d.out_pin  = pin_q[idx_i];
    out_d.out_mode = run_mode_q;
    case (cmd_i.emit_sel)
      EMIT_FIRST: begin
        out_d.kind      = KIND_WRITE;
        out_d.out_value = first_q[idx_i];
      end
      EMIT_SECOND: begin
        out_d.kind      = KIND_WRITE;
        out_d.out_value = second_q[idx_i];
      end
      EMIT_REPORT: begin
        out_d.kind       = KIND_REPORT;
        out_d.elapsed_ms = elapsed_q[idx_i];
        out_d.last       = cur_last;
      end
      default: begin
        out_d.kind = KIND_WRITE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_chan && load_ok) begin
      pin_q[load_idx]    <= in_data_i.pin;
      first_q[load_idx]  <= in_data_i.first_value;
      dur_q[load_idx]    <= in_data_i.duration_ms;
      second_q[load_idx] <= in_data_i.second_value;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      active_q    <= '0;
      run_time_q  <= '0;
      run_mode_q  <= MODE_DIGITAL;
      running_q   <= 1'b0;
      max_q       <= MAX_PULSE_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        elapsed_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (cmd_i.load_chan && load_ok) begin
        loaded_q[load_idx] <= 1'b1;
      end
      if (cmd_i.start_run) begin
        run_mode_q <= mode_d;
        run_time_q <= '0;
        running_q  <= 1'b1;
      end
      if (cmd_i.tick && run_time_q != TIME_SAT) begin
        run_time_q <= run_time_q + 16'd1;
      end
      if (cmd_i.set_active) begin
        active_q[idx_i]  <= 1'b1;
        elapsed_q[idx_i] <= '0;
      end
      if (cmd_i.finish_chan) begin
        active_q[idx_i]  <= 1'b0;
        elapsed_q[idx_i] <= run_time_q;
      end
      if (cmd_i.end_run) begin
        running_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> status_o.out_free)
    else $error("Result issued while the output register is occupied.");

  a_finish_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish_chan |-> active_q[idx_i])
    else $error("Channel finished without being active.");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start_run |=> (run_time_q == 16'd0) && running_q)
    else $error("Run start did not clear the timer.");

  a_idle_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (active_q == '0))
    else $error("Channel active outside a run.");

endmodule

// File: design/mcosp_ctrl.sv
// ----------------------------------------------------------------------------
// mcosp_ctrl
// Sequencer that scans the channel slots for start, settle and report passes.
// ----------------------------------------------------------------------------
module mcosp_ctrl #(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned IDX_W = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            op_i,
  input  mcosp_pkg::dp_status_t status_i,
  output mcosp_pkg::dp_cmd_t    cmd_o,
  output logic [IDX_W-1:0]      idx_o
);
  import mcosp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SETTLE,
    ST_REPORT
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             pending_q, pending_d;
  logic             at_end, advance;

  assign at_end     = idx_q == IDX_W'(SLOTS - 1);
  assign in_stall_o = state_q != ST_IDLE;
  assign idx_o      = idx_q;

  always_comb begin
    cmd_o     = '0;
    cmd_o.emit_sel = EMIT_FIRST;
    state_d   = state_q;
    idx_d     = idx_q;
    pending_d = pending_q;
    advance   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_LOAD: begin
              cmd_o.load_chan = !status_i.running;
            end
            OP_START: begin
              if (!status_i.running && status_i.any_loaded) begin
                cmd_o.start_run = 1'b1;
                idx_d   = '0;
                state_d = ST_START;
              end
            end
            OP_TICK: begin
              if (status_i.running) begin
                cmd_o.tick = 1'b1;
                idx_d     = '0;
                pending_d = 1'b0;
                state_d   = ST_SETTLE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_START: begin
        cmd_o.emit_sel = EMIT_FIRST;
        if (status_i.cur_loaded) begin
          if (status_i.out_free) begin
            cmd_o.emit       = 1'b1;
            cmd_o.set_active = 1'b1;
            advance          = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          if (at_end) begin
            idx_d     = '0;
            pending_d = 1'b0;
            state_d   = ST_SETTLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      ST_SETTLE: begin
        cmd_o.emit_sel = EMIT_SECOND;
        if (status_i.cur_active) begin
          if (status_i.cur_due) begin
            if (status_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.finish_chan = 1'b1;
              advance           = 1'b1;
            end
          end else begin
            pending_d = 1'b1;
            advance   = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          if (at_end) begin
            idx_d   = '0;
            state_d = pending_d ? ST_IDLE : ST_REPORT;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      ST_REPORT: begin
        cmd_o.emit_sel = EMIT_REPORT;
        if (status_i.cur_loaded) begin
          if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
            advance    = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          if (at_end) begin
            cmd_o.end_run = 1'b1;
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      pending_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      pending_q <= pending_d;
    end
  end

endmodule

// File: design/multi_channel_one_shot_pulser.sv
// Loads and ignored items need no slot pass. A tick in a run makes a settle pass over the
// S = min(NUM_CHANNELS, 8) slots; a start makes a start pass and a settle pass; a report
// pass follows when the run ends. One slot is visited per cycle unless its result stalls;
// a result appears in the cycle after its slot is visited; one item is handled at a time.
// Reset clears the loaded and active flags, the timer and the run state, and sets
// the limit register to 65535; channel settings are undefined until loaded.
// ----------------------------------------------------------------------------
// multi_channel_one_shot_pulser
// Multi-channel one-shot pulse timer with pin write events and run reports.
// ----------------------------------------------------------------------------
module multi_channel_one_shot_pulser #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mcosp_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mcosp_pkg::out_item_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);
  import mcosp_pkg::*;

  localparam int unsigned SLOTS = (NUM_CHANNELS < CHAN_SLOT_MAX) ? NUM_CHANNELS : CHAN_SLOT_MAX;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [IDX_W-1:0] idx;

  mcosp_ctrl #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (in_data_i.op),
    .status_i   (status),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  mcosp_dpath #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: verif/tb_multi_channel_one_shot_pulser.sv
// ----------------------------------------------------------------------------
// tb_multi_channel_one_shot_pulser
// Self-checking testbench for the multi-channel one-shot pulser. Directed
// tests cover idle items, a basic run, the limit register and a long output
// hold-off. Random runs then load channels, start runs and tick them to the
// end. A behavioral copy of the timer predicts every pin write and report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_channel_one_shot_pulser;
  import mcosp_pkg::*;

  localparam int unsigned NCH           = 8;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [1:0]  OP_NONE       = 2'd3;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  bit          gaps_on     = 1'b1;
  int unsigned hold_left   = 0;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;

  out_item_t   expected_results[$];

  logic [5:0]  slot_pin     [NCH];
  logic [7:0]  slot_first   [NCH];
  logic [15:0] slot_dur     [NCH];
  logic [7:0]  slot_second  [NCH];
  bit          slot_loaded  [NCH] = '{default: 1'b0};
  bit          slot_pending [NCH] = '{default: 1'b0};
  logic [15:0] slot_elapsed [NCH] = '{default: 16'd0};
  logic [15:0] run_ms    = '0;
  logic [1:0]  run_wmode = MODE_DIGITAL;
  bit          run_on    = 1'b0;
  logic [15:0] limit_ms  = MAX_PULSE_RESET;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  multi_channel_one_shot_pulser #(
    .NUM_CHANNELS(NCH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  function automatic void push_result(logic kind, logic [5:0] pin, logic [7:0] value,
                                      logic [15:0] elapsed, logic last);
    out_item_t r;
    r.kind       = kind;
    r.out_pin    = pin;
    r.out_value  = value;
    r.out_mode   = run_wmode;
    r.elapsed_ms = elapsed;
    r.last       = last;
    expected_results.push_back(r);
  endfunction

  function automatic void close_due_slots();
    bit waiting;
    int final_slot;
    waiting    = 1'b0;
    final_slot = -1;
    for (int i = 0; i < NCH; i++) begin
      if (slot_pending[i]) begin
        if (run_ms >= slot_dur[i] || run_ms >= limit_ms) begin
          push_result(KIND_WRITE, slot_pin[i], slot_second[i], '0, 1'b0);
          slot_elapsed[i] = run_ms;
          slot_pending[i] = 1'b0;
        end else begin
          waiting = 1'b1;
        end
      end
    end
    if (!waiting) begin
      for (int i = 0; i < NCH; i++)
        if (slot_loaded[i]) final_slot = i;
      for (int i = 0; i < NCH; i++)
        if (slot_loaded[i])
          push_result(KIND_REPORT, slot_pin[i], '0, slot_elapsed[i], i == final_slot);
      run_on = 1'b0;
    end
  endfunction

  function automatic void predict_results(in_item_t it);
    bit any_loaded;
    any_loaded = 1'b0;
    case (it.op)
      OP_LOAD: begin
        if (!run_on && it.chan < NCH) begin
          slot_pin[it.chan]    = it.pin;
          slot_first[it.chan]  = it.first_value;
          slot_dur[it.chan]    = it.duration_ms;
          slot_second[it.chan] = it.second_value;
          slot_loaded[it.chan] = 1'b1;
        end
      end
      OP_START: begin
        for (int i = 0; i < NCH; i++)
          if (slot_loaded[i]) any_loaded = 1'b1;
        if (!run_on && any_loaded) begin
          run_wmode = (it.write_mode == MODE_UNUSED) ? MODE_DRY : it.write_mode;
          run_ms    = '0;
          run_on    = 1'b1;
          for (int i = 0; i < NCH; i++) begin
            if (slot_loaded[i]) begin
              push_result(KIND_WRITE, slot_pin[i], slot_first[i], '0, 1'b0);
              slot_pending[i] = 1'b1;
              slot_elapsed[i] = '0;
            end
          end
          close_due_slots();
        end
      end
      OP_TICK: begin
        if (run_on) begin
          if (run_ms != TIME_SAT) run_ms = run_ms + 16'd1;
          close_due_slots();
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic in_item_t random_item(logic [1:0] op);
    in_item_t it;
    it.op           = op;
    it.chan         = 3'($urandom_range(7));
    it.pin          = 6'($urandom_range(63));
    it.first_value  = 8'($urandom_range(255));
    it.duration_ms  = 16'($urandom_range(65535));
    it.second_value = 8'($urandom_range(255));
    it.write_mode   = 2'($urandom_range(3));
    return it;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, out_data_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_data_o.kind));
        check_field("out_pin", 16'(want.out_pin), 16'(out_data_o.out_pin));
        check_field("out_value", 16'(want.out_value), 16'(out_data_o.out_value));
        check_field("out_mode", 16'(want.out_mode), 16'(out_data_o.out_mode));
        check_field("elapsed_ms", want.elapsed_ms, out_data_o.elapsed_ms);
        check_field("last", 16'(want.last), 16'(out_data_o.last));
      end
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= gaps_on && ($urandom_range(99) < 35);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transactions outstanding", $time,
               expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    while (gaps_on && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_results(it);
  endtask

  task automatic send_load(logic [2:0] chan, logic [5:0] pin, logic [7:0] first,
                           logic [15:0] dur, logic [7:0] second);
    in_item_t it;
    it              = random_item(OP_LOAD);
    it.chan         = chan;
    it.pin          = pin;
    it.first_value  = first;
    it.duration_ms  = dur;
    it.second_value = second;
    send_item(it);
  endtask

  task automatic send_op(logic [1:0] op, logic [1:0] mode);
    in_item_t it;
    it            = random_item(op);
    it.write_mode = mode;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_ms     = value;
  endtask

  task automatic test_idle_items();
    send_op(OP_START, MODE_ANALOG);
    send_op(OP_TICK, MODE_DIGITAL);
    send_op(OP_NONE, MODE_DRY);
  endtask

  task automatic test_basic_run();
    send_load(3'd0, 6'd0, 8'h00, 16'd0, 8'hFF);
    send_load(3'd7, 6'd63, 8'hFF, 16'd2, 8'h00);
    send_load(3'd3, 6'd21, 8'hA5, 16'd1, 8'h5A);
    send_op(OP_START, MODE_DIGITAL);
    send_op(OP_TICK, MODE_DIGITAL);
    send_load(3'd5, 6'd9, 8'h11, 16'd4, 8'h22);
    send_op(OP_START, MODE_ANALOG);
    send_op(OP_NONE, MODE_UNUSED);
    send_op(OP_TICK, MODE_UNUSED);
  endtask

  task automatic test_limit_cases();
    write_limit(16'd0);
    send_op(OP_START, MODE_UNUSED);
    write_limit(16'd2);
    send_load(3'd5, 6'd42, 8'h3C, 16'hFFFF, 8'hC3);
    send_op(OP_START, MODE_ANALOG);
    send_op(OP_TICK, MODE_DRY);
    send_op(OP_TICK, MODE_DIGITAL);
    send_op(OP_TICK, MODE_ANALOG);
  endtask

  task automatic test_output_backpressure();
    write_limit(MAX_PULSE_RESET);
    gaps_on = 1'b0;
    for (int i = 0; i < NCH; i++)
      send_load(3'(i), 6'($urandom_range(63)), 8'($urandom_range(255)), 16'd0,
                8'($urandom_range(255)));
    hold_left = 400;
    repeat (3) send_op(OP_START, 2'($urandom_range(3)));
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_runs(int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    logic [15:0] lim;
    logic [15:0] dur;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(9);
      if (pick == 0) lim = '0;
      else if (pick < 3) lim = MAX_PULSE_RESET;
      else if (pick < 5) lim = 16'($urandom_range(65535));
      else lim = 16'($urandom_range(1, 6));
      write_limit(lim);
      if (lim > 20) begin
        for (int i = 0; i < NCH; i++) begin
          if (slot_loaded[i] && slot_dur[i] > 20) begin
            send_load(3'(i), 6'($urandom_range(63)), 8'($urandom_range(255)),
                      16'($urandom_range(12)), 8'($urandom_range(255)));
            sent++;
          end
        end
      end
      repeat ($urandom_range(1, 4)) begin
        if (lim <= 20 && $urandom_range(1) == 1) dur = 16'($urandom_range(65535));
        else dur = 16'($urandom_range(12));
        send_load(3'($urandom_range(7)), 6'($urandom_range(63)), 8'($urandom_range(255)),
                  dur, 8'($urandom_range(255)));
        sent++;
      end
      if ($urandom_range(3) == 0) send_item(random_item(OP_NONE));
      if ($urandom_range(3) == 0) send_item(random_item(OP_TICK));
      send_op(OP_START, 2'($urandom_range(3)));
      sent++;
      while (run_on) begin
        case ($urandom_range(11))
          0: send_item(random_item(OP_LOAD));
          1: send_item(random_item(OP_START));
          2: send_item(random_item(OP_NONE));
          default: begin
            send_item(random_item(OP_TICK));
            sent++;
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_items();
    test_basic_run();
    test_limit_cases();
    test_output_backpressure();
    gaps_on = 1'b0;
    test_random_runs(25);
    gaps_on = 1'b1;
    test_random_runs(45);
    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
